FILE: sv/cbu_pkg.sv
// Shared types and codes for the color blend unit.
// Holds factor select codes, blend operation codes and the configuration struct.
// No dependencies.
package cbu_pkg;

    // Factor select codes (codes above FACTOR_ONE_MINUS_DST_ALPHA act as zero)
    localparam logic [3:0] FACTOR_ONE                 = 4'd0;
    localparam logic [3:0] FACTOR_ZERO                = 4'd1;
    localparam logic [3:0] FACTOR_SRC_COLOR           = 4'd2;
    localparam logic [3:0] FACTOR_ONE_MINUS_SRC_COLOR = 4'd3;
    localparam logic [3:0] FACTOR_DST_COLOR           = 4'd4;
    localparam logic [3:0] FACTOR_ONE_MINUS_DST_COLOR = 4'd5;
    localparam logic [3:0] FACTOR_SRC_ALPHA           = 4'd6;
    localparam logic [3:0] FACTOR_ONE_MINUS_SRC_ALPHA = 4'd7;
    localparam logic [3:0] FACTOR_DST_ALPHA           = 4'd8;
    localparam logic [3:0] FACTOR_ONE_MINUS_DST_ALPHA = 4'd9;

    // Blend operation codes (unused codes act as add)
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SUB     = 3'd1;
    localparam logic [2:0] OP_REV_SUB = 3'd2;
    localparam logic [2:0] OP_MIN     = 3'd3;
    localparam logic [2:0] OP_MAX     = 3'd4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SRC_FACTOR = 2'd0;
    localparam logic [1:0] REG_DST_FACTOR = 2'd1;
    localparam logic [1:0] REG_BLEND_OP   = 2'd2;

    // Reset values
    localparam logic [3:0] SRC_FACTOR_RESET = FACTOR_ONE;
    localparam logic [3:0] DST_FACTOR_RESET = FACTOR_ZERO;
    localparam logic [2:0] BLEND_OP_RESET   = OP_ADD;

    typedef struct packed {
        logic [3:0] src_factor_sel;
        logic [3:0] dst_factor_sel;
        logic [2:0] blend_op;
    } cbu_cfg_t;

endpackage

FILE: sv/cbu_pix_if.sv
// Input channel of the color blend unit: one source and one destination RGBA pixel per beat.
// Valid/ready handshake; no package dependency.
interface cbu_pix_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] src_red;
    logic [CHANNEL_BITS-1:0] src_green;
    logic [CHANNEL_BITS-1:0] src_blue;
    logic [CHANNEL_BITS-1:0] src_alpha;
    logic [CHANNEL_BITS-1:0] dst_red;
    logic [CHANNEL_BITS-1:0] dst_green;
    logic [CHANNEL_BITS-1:0] dst_blue;
    logic [CHANNEL_BITS-1:0] dst_alpha;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha,
               dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );

    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha,
               dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

FILE: sv/cbu_rgba_if.sv
// Output channel of the color blend unit: one blended RGBA pixel per beat.
// Valid/ready handshake; no package dependency.
interface cbu_rgba_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [CHANNEL_BITS-1:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

FILE: sv/cbu_cfg_regs.sv
// APB-style configuration registers of the color blend unit.
// Depends on cbu_pkg for register indexes, reset values and the config struct.
module cbu_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cbu_pkg::cbu_cfg_t cfg
);

    cbu_pkg::cbu_cfg_t cfg_reg;
    cbu_pkg::cbu_cfg_t cfg_next;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Decode the write beat into the register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                cbu_pkg::REG_SRC_FACTOR: cfg_next.src_factor_sel = pwdata[3:0];
                cbu_pkg::REG_DST_FACTOR: cfg_next.dst_factor_sel = pwdata[3:0];
                cbu_pkg::REG_BLEND_OP:   cfg_next.blend_op       = pwdata[2:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_factor_sel <= cbu_pkg::SRC_FACTOR_RESET;
            cfg_reg.dst_factor_sel <= cbu_pkg::DST_FACTOR_RESET;
            cfg_reg.blend_op       <= cbu_pkg::BLEND_OP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            cbu_pkg::REG_SRC_FACTOR: prdata = {28'd0, cfg_reg.src_factor_sel};
            cbu_pkg::REG_DST_FACTOR: prdata = {28'd0, cfg_reg.dst_factor_sel};
            cbu_pkg::REG_BLEND_OP:   prdata = {29'd0, cfg_reg.blend_op};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/cbu_channel.sv
// One color channel of the blend datapath: factor select, two normalized
// multiplies and the blend operation with saturation. Depends on cbu_pkg.
module cbu_channel #(
    parameter int CHANNEL_BITS = 8
) (
    input  cbu_pkg::cbu_cfg_t        cfg,
    input  logic [CHANNEL_BITS-1:0]  src_col,
    input  logic [CHANNEL_BITS-1:0]  dst_col,
    input  logic [CHANNEL_BITS-1:0]  src_a,
    input  logic [CHANNEL_BITS-1:0]  dst_a,
    output logic [CHANNEL_BITS-1:0]  result
);

    localparam int N = CHANNEL_BITS;
    localparam logic [N-1:0]   CH_MAX  = {N{1'b1}};
    localparam logic [2*N+1:0] MAX_W   = {{(N+2){1'b0}}, CH_MAX};
    localparam logic [2*N+1:0] MAX_W2  = {{(N+1){1'b0}}, CH_MAX, 1'b0};
    localparam logic [2*N+1:0] HALF_W  = {{(N+3){1'b0}}, {(N-1){1'b1}}};

    // Pick the weight for one term
    function automatic logic [N-1:0] pick_factor(
        input logic [3:0]   sel,
        input logic [N-1:0] sc,
        input logic [N-1:0] dc,
        input logic [N-1:0] sa,
        input logic [N-1:0] da
    );
        logic [N-1:0] f;
        case (sel)
            cbu_pkg::FACTOR_ONE:                 f = CH_MAX;
            cbu_pkg::FACTOR_ZERO:                f = '0;
            cbu_pkg::FACTOR_SRC_COLOR:           f = sc;
            cbu_pkg::FACTOR_ONE_MINUS_SRC_COLOR: f = CH_MAX - sc;
            cbu_pkg::FACTOR_DST_COLOR:           f = dc;
            cbu_pkg::FACTOR_ONE_MINUS_DST_COLOR: f = CH_MAX - dc;
            cbu_pkg::FACTOR_SRC_ALPHA:           f = sa;
            cbu_pkg::FACTOR_ONE_MINUS_SRC_ALPHA: f = CH_MAX - sa;
            cbu_pkg::FACTOR_DST_ALPHA:           f = da;
            cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA: f = CH_MAX - da;
            default:                             f = '0;
        endcase
        return f;
    endfunction

    // a*b/(2^N-1) rounded to nearest: estimate the quotient with a shift-add
    // reciprocal of 2^N-1, then fix it up from the remainder (at most +2)
    function automatic logic [N-1:0] norm_mul(
        input logic [N-1:0] a,
        input logic [N-1:0] b
    );
        logic [2*N+1:0] x;
        logic [2*N+1:0] q_est;
        logic [2*N+1:0] rem;
        logic [2*N+1:0] q;
        x     = ({{(N+2){1'b0}}, a} * {{(N+2){1'b0}}, b}) + HALF_W;
        q_est = (x + (x >> N)) >> N;
        rem   = x - (q_est << N) + q_est;
        if (rem >= MAX_W2)
        begin
            q = q_est + 2'd2;
        end
        else if (rem >= MAX_W)
        begin
            q = q_est + 1'b1;
        end
        else
        begin
            q = q_est;
        end
        return q[N-1:0];
    endfunction

    logic [N-1:0] src_factor;
    logic [N-1:0] dst_factor;
    logic [N-1:0] src_term;
    logic [N-1:0] dst_term;
    logic [N:0]   term_sum;

    assign src_factor = pick_factor(cfg.src_factor_sel, src_col, dst_col, src_a, dst_a);
    assign dst_factor = pick_factor(cfg.dst_factor_sel, src_col, dst_col, src_a, dst_a);
    assign src_term   = norm_mul(src_col, src_factor);
    assign dst_term   = norm_mul(dst_col, dst_factor);
    assign term_sum   = {1'b0, src_term} + {1'b0, dst_term};

    // Join the weighted terms and saturate
    always_comb
    begin
        case (cfg.blend_op)
            cbu_pkg::OP_SUB:     result = (src_term > dst_term) ? src_term - dst_term : '0;
            cbu_pkg::OP_REV_SUB: result = (dst_term > src_term) ? dst_term - src_term : '0;
            cbu_pkg::OP_MIN:     result = (src_term < dst_term) ? src_term : dst_term;
            cbu_pkg::OP_MAX:     result = (src_term > dst_term) ? src_term : dst_term;
            default:             result = term_sum[N] ? CH_MAX : term_sum[N-1:0];
        endcase
    end

endmodule

FILE: sv/color_blend_unit.sv
// Color blend unit top level: input register, four blend channels, result register.
// Depends on cbu_pkg, cbu_pix_if, cbu_rgba_if, cbu_cfg_regs and cbu_channel.
//
// Usage:
//   pix_in carries one beat per source/destination RGBA pixel pair; pix_out
//   carries one blended RGBA pixel per input beat, in the same order.
//   The APB port sets the source factor (byte address 0), destination factor
//   (address 4) and blend operation (address 8); write it only while idle.
// Data path: a pixel accepted into the input register is blended combinationally
//   and moves into the result register, which drives pix_out, once that register
//   drains or is empty.
// Throughput: one pixel per clock; the input register and the result register
//   form a two-stage pipe, so a new beat is taken every cycle that pix_out
//   drains or has room.
// Stall: when pix_out.ready is low the result register holds its beat, the
//   input register fills, and pix_in.ready then drops until pix_out drains.
// Reset: rst_n clears both pipe stages to empty and the registers to source
//   factor one, destination factor zero, operation add.
module color_blend_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    cbu_pix_if.sink     pix_in,
    cbu_rgba_if.source  pix_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = CHANNEL_BITS;

    cbu_pkg::cbu_cfg_t cfg;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [N-1:0]     src_reg [4];
    logic [N-1:0]     dst_reg [4];
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [N-1:0]     res_reg [4];
    logic [N-1:0]     blend   [4];
    logic             out_load;
    logic             in_load;

    cbu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance stages when the stage ahead has room
    assign out_load     = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !in_valid_reg || out_load;
    assign in_load      = pix_in.valid && pix_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (pix_in.ready)
        begin
            in_valid_next = pix_in.valid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            src_reg[0] <= pix_in.src_red;
            src_reg[1] <= pix_in.src_green;
            src_reg[2] <= pix_in.src_blue;
            src_reg[3] <= pix_in.src_alpha;
            dst_reg[0] <= pix_in.dst_red;
            dst_reg[1] <= pix_in.dst_green;
            dst_reg[2] <= pix_in.dst_blue;
            dst_reg[3] <= pix_in.dst_alpha;
        end
    end

    // Blend each channel; alpha factors come from the alpha lane
    for (genvar c = 0; c < 4; c++)
    begin : g_chan
        cbu_channel #(
            .CHANNEL_BITS (N)
        ) u_chan (
            .cfg     (cfg),
            .src_col (src_reg[c]),
            .dst_col (dst_reg[c]),
            .src_a   (src_reg[3]),
            .dst_a   (dst_reg[3]),
            .result  (blend[c])
        );
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            res_reg <= blend;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = res_reg[0];
    assign pix_out.out_green = res_reg[1];
    assign pix_out.out_blue  = res_reg[2];
    assign pix_out.out_alpha = res_reg[3];

endmodule

FILE: bench/cbu_blend_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the color blend unit: snoops the APB writes, predicts each blended pixel.
// Depends on cbu_pkg and the cbu_pix_if / cbu_rgba_if interfaces.
module cbu_blend_checker (
    input  logic        clk,
    input  logic        rst_n,
    cbu_pix_if          pix_in,
    cbu_rgba_if         pix_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending_pixels,
    output int          pixels_blended
);

    // Channel 0 red .. channel 3 alpha
    typedef logic [3:0][7:0] rgba_t;

    localparam int ALPHA_CH     = 3;
    localparam int REPORT_LIMIT = 40;

    cbu_pkg::cbu_cfg_t blend_cfg;
    rgba_t             blended_q[$];
    int                err_cnt;
    int                out_cnt;

    function automatic string chan_name(input int c);
        case (c)
            0:       return "out_red";
            1:       return "out_green";
            2:       return "out_blue";
            default: return "out_alpha";
        endcase
    endfunction

    // Normalized product a*b/255, rounded to nearest
    function automatic logic [7:0] scale_chan(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] prod;
        logic [16:0] quot;
        prod = {9'd0, a} * {9'd0, b} + 17'd127;
        quot = prod / 17'd255;
        return quot[7:0];
    endfunction

    function automatic logic [7:0] factor_value(input logic [3:0] sel, input rgba_t s,
                                                input rgba_t d, input int c);
        case (sel)
            cbu_pkg::FACTOR_ONE:                 return 8'hFF;
            cbu_pkg::FACTOR_ZERO:                return 8'h00;
            cbu_pkg::FACTOR_SRC_COLOR:           return s[c];
            cbu_pkg::FACTOR_ONE_MINUS_SRC_COLOR: return 8'hFF - s[c];
            cbu_pkg::FACTOR_DST_COLOR:           return d[c];
            cbu_pkg::FACTOR_ONE_MINUS_DST_COLOR: return 8'hFF - d[c];
            cbu_pkg::FACTOR_SRC_ALPHA:           return s[ALPHA_CH];
            cbu_pkg::FACTOR_ONE_MINUS_SRC_ALPHA: return 8'hFF - s[ALPHA_CH];
            cbu_pkg::FACTOR_DST_ALPHA:           return d[ALPHA_CH];
            cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA: return 8'hFF - d[ALPHA_CH];
            default:                             return 8'h00;
        endcase
    endfunction

    // Weight both terms, join them per channel, saturate to 0..255
    function automatic rgba_t blend_pixel(input cbu_pkg::cbu_cfg_t cfg, input rgba_t s,
                                          input rgba_t d);
        rgba_t      res;
        logic [7:0] ts;
        logic [7:0] td;
        logic [8:0] sum;
        for (int c = 0; c < 4; c++) begin
            ts = scale_chan(s[c], factor_value(cfg.src_factor_sel, s, d, c));
            td = scale_chan(d[c], factor_value(cfg.dst_factor_sel, s, d, c));
            case (cfg.blend_op)
                cbu_pkg::OP_SUB:     res[c] = (ts > td) ? ts - td : 8'd0;
                cbu_pkg::OP_REV_SUB: res[c] = (td > ts) ? td - ts : 8'd0;
                cbu_pkg::OP_MIN:     res[c] = (ts < td) ? ts : td;
                cbu_pkg::OP_MAX:     res[c] = (ts > td) ? ts : td;
                default:
                begin
                    sum    = {1'b0, ts} + {1'b0, td};
                    res[c] = sum[8] ? 8'hFF : sum[7:0];
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgba_t src_px;
        rgba_t dst_px;
        rgba_t want;
        rgba_t got;
        if (!rst_n)
        begin
            blend_cfg = {cbu_pkg::SRC_FACTOR_RESET, cbu_pkg::DST_FACTOR_RESET,
                         cbu_pkg::BLEND_OP_RESET};
            blended_q.delete();
            err_cnt = 0;
            out_cnt = 0;
            mismatches     <= 0;
            pending_pixels <= 0;
            pixels_blended <= 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    cbu_pkg::REG_SRC_FACTOR: blend_cfg.src_factor_sel = pwdata[3:0];
                    cbu_pkg::REG_DST_FACTOR: blend_cfg.dst_factor_sel = pwdata[3:0];
                    cbu_pkg::REG_BLEND_OP:   blend_cfg.blend_op       = pwdata[2:0];
                    default:                 ;
                endcase
            end

            // Predict the result of each accepted input beat
            if (pix_in.valid && pix_in.ready)
            begin
                src_px = {pix_in.src_alpha, pix_in.src_blue, pix_in.src_green, pix_in.src_red};
                dst_px = {pix_in.dst_alpha, pix_in.dst_blue, pix_in.dst_green, pix_in.dst_red};
                blended_q.push_back(blend_pixel(blend_cfg, src_px, dst_px));
            end

            // Compare each output beat with the oldest prediction
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.out_alpha, pix_out.out_blue, pix_out.out_green, pix_out.out_red};
                if (blended_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display("%0t: unexpected output beat %0d, got %h", $time, out_cnt, got);
                end
                else
                begin
                    want = blended_q.pop_front();
                    for (int c = 0; c < 4; c++)
                    begin
                        if (got[c] !== want[c])
                        begin
                            err_cnt++;
                            // keep the log readable once things go badly wrong
                            if (err_cnt <= REPORT_LIMIT)
                                $display("%0t: pixel %0d %s expected %0d got %0d",
                                         $time, out_cnt, chan_name(c), want[c], got[c]);
                        end
                    end
                end
                out_cnt++;
            end

            mismatches     <= err_cnt;
            pending_pixels <= blended_q.size();
            pixels_blended <= out_cnt;
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the color blend unit bench: clock, reset, pixel and APB stimulus, verdict.
// Depends on cbu_pkg, the pixel interfaces, color_blend_unit and cbu_blend_checker.
module tb_top;

    // Entries [3:0] source RGBA, [7:4] destination RGBA, red lowest
    typedef logic [7:0][7:0] pix_pair_t;

    localparam int CLK_PERIOD        = 4;
    localparam int RESET_CYCLES      = 5;
    localparam int TOTAL_PAIRS       = 1650;
    localparam int PIPE_QUIET_CYCLES = 4;
    localparam int END_QUIET_CYCLES  = 10;
    localparam int RX_HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int HEAVY_IDLE_PCT    = 69;
    localparam int LIGHT_IDLE_PCT    = 22;

    localparam logic [3:0] FACTOR_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] FACTOR_UNUSED_LAST  = 4'd15;
    localparam logic [2:0] OP_UNUSED_FIRST     = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST      = 3'd7;

    localparam pix_pair_t PAIR_ZERO     = 64'h00000000_00000000;
    localparam pix_pair_t PAIR_FULL     = 64'hFFFFFFFF_FFFFFFFF;
    localparam pix_pair_t PAIR_SRC_ONLY = 64'h00000000_FFFFFFFF;
    localparam pix_pair_t PAIR_DST_ONLY = 64'hFFFFFFFF_00000000;
    localparam pix_pair_t PAIR_MIXED    = 64'h80FF7F01_7F0180FE;
    localparam pix_pair_t PAIR_CHECKER  = 64'h55AA55AA_AA55AA55;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending_pixels;
    int pixels_blended;
    int pairs_sent;
    int config_phases;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_req_num;
    int hold_seen_num;
    int hold_left;
    int idle_cycles;

    cbu_pix_if  #(.CHANNEL_BITS(8)) pix_in ();
    cbu_rgba_if #(.CHANNEL_BITS(8)) pix_out ();

    color_blend_unit #(.CHANNEL_BITS(8)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cbu_blend_checker blend_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatches     (mismatches),
        .pending_pixels (pending_pixels),
        .pixels_blended (pixels_blended)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        pix_out.ready = 1'b0;
        hold_seen_num = 0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req_num != hold_seen_num)
            begin
                hold_seen_num = hold_req_num;
                hold_left     = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else
                pix_out.ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("[color_blend_unit] ERROR");
            $finish;
        end
    end

    function automatic pix_pair_t random_pair();
        pix_pair_t p;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 7))
                0:       p[i] = 8'h00;
                1:       p[i] = 8'hFF;
                default: p[i] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // Random bits above the register field, now and then
    function automatic logic [31:0] with_junk(input logic [31:0] val, input logic [31:0] mask);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
        return (junk & ~mask) | val;
    endfunction

    task automatic drive_pair(input pix_pair_t p);
        pix_in.src_red   <= p[0];
        pix_in.src_green <= p[1];
        pix_in.src_blue  <= p[2];
        pix_in.src_alpha <= p[3];
        pix_in.dst_red   <= p[4];
        pix_in.dst_green <= p[5];
        pix_in.dst_blue  <= p[6];
        pix_in.dst_alpha <= p[7];
    endtask

    // Offer one beat, with random idle cycles ahead of it, and hold until taken
    task automatic send_pair(input pix_pair_t p);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            drive_pair(random_pair());
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        drive_pair(p);
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Drop valid and wait for every predicted pixel to come out
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (PIPE_QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [3:0] sf, input logic [3:0] df, input logic [2:0] bo);
        wait_idle();
        apb_write(cbu_pkg::REG_SRC_FACTOR, with_junk({28'd0, sf}, 32'h0000_000F));
        apb_write(cbu_pkg::REG_DST_FACTOR, with_junk({28'd0, df}, 32'h0000_000F));
        apb_write(cbu_pkg::REG_BLEND_OP, with_junk({29'd0, bo}, 32'h0000_0007));
        config_phases++;
    endtask

    initial
    begin
        int         phase_idx;
        int         n;
        logic [3:0] sf;
        logic [3:0] df;
        logic [2:0] bo;

        rst_n         = 1'b0;
        pairs_sent    = 0;
        config_phases = 0;
        tx_idle_pct   = 0;
        pix_in.valid <= 1'b0;
        drive_pair(PAIR_ZERO);
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rx_stall_pct <= 0;
        hold_req_num <= 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, saturation, each operation, unused codes
        send_pair(PAIR_ZERO);
        send_pair(PAIR_FULL);
        send_pair(PAIR_SRC_ONLY);
        send_pair(PAIR_DST_ONLY);
        write_config(cbu_pkg::FACTOR_ONE, cbu_pkg::FACTOR_ONE, cbu_pkg::OP_ADD);
        send_pair(PAIR_FULL);
        send_pair(PAIR_MIXED);
        write_config(cbu_pkg::FACTOR_ONE, cbu_pkg::FACTOR_ONE, cbu_pkg::OP_SUB);
        send_pair(PAIR_SRC_ONLY);
        send_pair(PAIR_DST_ONLY);
        send_pair(PAIR_CHECKER);
        write_config(cbu_pkg::FACTOR_ONE, cbu_pkg::FACTOR_ONE, cbu_pkg::OP_REV_SUB);
        send_pair(PAIR_SRC_ONLY);
        send_pair(PAIR_DST_ONLY);
        write_config(cbu_pkg::FACTOR_SRC_ALPHA, cbu_pkg::FACTOR_ONE_MINUS_SRC_ALPHA,
                     cbu_pkg::OP_ADD);
        send_pair(PAIR_MIXED);
        send_pair(PAIR_CHECKER);
        write_config(cbu_pkg::FACTOR_DST_ALPHA, cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA,
                     cbu_pkg::OP_MIN);
        send_pair(PAIR_MIXED);
        send_pair(PAIR_CHECKER);
        write_config(cbu_pkg::FACTOR_SRC_COLOR, cbu_pkg::FACTOR_DST_COLOR, cbu_pkg::OP_MAX);
        send_pair(PAIR_MIXED);
        send_pair(PAIR_CHECKER);
        write_config(cbu_pkg::FACTOR_ONE_MINUS_SRC_COLOR, cbu_pkg::FACTOR_ONE_MINUS_DST_COLOR,
                     OP_UNUSED_LAST);
        send_pair(PAIR_MIXED);
        send_pair(PAIR_FULL);
        write_config(FACTOR_UNUSED_LAST, cbu_pkg::FACTOR_ONE, OP_UNUSED_FIRST);
        send_pair(PAIR_MIXED);
        send_pair(PAIR_CHECKER);

        // Random phases: new settings each time, rotating idle and stall mixes
        phase_idx = 0;
        while (pairs_sent < TOTAL_PAIRS)
        begin
            if (phase_idx % 6 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       sf = cbu_pkg::FACTOR_ONE;
                    1:       sf = cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA;
                    default: sf = FACTOR_UNUSED_LAST;
                endcase
                case ($urandom_range(0, 2))
                    0:       df = cbu_pkg::FACTOR_ONE;
                    1:       df = cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA;
                    default: df = FACTOR_UNUSED_LAST;
                endcase
                case ($urandom_range(0, 2))
                    0:       bo = cbu_pkg::OP_ADD;
                    1:       bo = cbu_pkg::OP_MAX;
                    default: bo = OP_UNUSED_LAST;
                endcase
            end
            else
            begin
                sf = ($urandom_range(0, 4) == 0)
                   ? 4'($urandom_range(FACTOR_UNUSED_FIRST, FACTOR_UNUSED_LAST))
                   : 4'($urandom_range(cbu_pkg::FACTOR_ONE,
                                       cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA));
                df = ($urandom_range(0, 4) == 0)
                   ? 4'($urandom_range(FACTOR_UNUSED_FIRST, FACTOR_UNUSED_LAST))
                   : 4'($urandom_range(cbu_pkg::FACTOR_ONE,
                                       cbu_pkg::FACTOR_ONE_MINUS_DST_ALPHA));
                bo = ($urandom_range(0, 4) == 0)
                   ? 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST))
                   : 3'($urandom_range(cbu_pkg::OP_ADD, cbu_pkg::OP_MAX));
            end
            write_config(sf, df, bo);

            case (phase_idx % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle_pct = HEAVY_IDLE_PCT;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= HEAVY_IDLE_PCT;
                end
                default:
                begin
                    tx_idle_pct = LIGHT_IDLE_PCT;
                    rx_stall_pct <= LIGHT_IDLE_PCT;
                end
            endcase

            // Hold the output off while the input keeps pushing, so the pipe backs up
            if (phase_idx == 2 || phase_idx == 13)
            begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
                hold_req_num <= hold_req_num + 1;
            end

            n = $urandom_range(20, 60);
            repeat (n) send_pair(random_pair());
            phase_idx++;
        end

        // Drain and give the verdict
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (END_QUIET_CYCLES) @(posedge clk);

        $display("Blended %0d pixels over %0d register settings, all factor and op codes,",
                 pixels_blended, config_phases);
        $display("under idle and stall mixes with two long output hold-offs.");
        if (mismatches == 0 && pending_pixels == 0)
            $display("[color_blend_unit] OK");
        else
            $display("[color_blend_unit] ERROR");
        $finish;
    end

endmodule
